// ===== rtl/core/psu_pkg.sv =====
// shared types and constants for the png scanline unfilter block
// no dependencies
package psu_pkg;

   localparam int BPP      = 4;
   localparam int BPP_LOG2 = 2;
   localparam int CSR_AW   = 3;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      filter_type_type        filter;
      logic [BPP_LOG2-1:0]    lane;
      logic                   first_pix;
      logic                   top_row;
      logic                   row_end;
      logic                   frame_end;
      logic                   bad_filter;
   } s1_ctl_type;

endpackage

// ===== rtl/core/psu_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/psu_csr.sv =====
// frame size registers behind the apb-style configuration port
// depends on psu_pkg
module psu_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [psu_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output logic [12:0]                   frame_width,
   output logic [15:0]                   frame_height
);

   logic [12:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        wr_fire;
   psu_pkg::reg_index_type sel;

   assign csr_pready = 1'b1;
   assign sel        = psu_pkg::reg_index_type'(csr_paddr[2]);
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_fire) begin
         case (sel)
            psu_pkg::REG_WIDTH:  width_in  = csr_pwdata[12:0];
            psu_pkg::REG_HEIGHT: height_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 16'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (sel)
         psu_pkg::REG_WIDTH:  csr_prdata = {19'd0, width_ff};
         psu_pkg::REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign frame_width  = width_ff;
   assign frame_height = height_ff;

endmodule

// ===== rtl/core/psu_recon.sv =====
// per-byte filter reconstruction: left and upper-left history plus predictor
// depends on psu_pkg
module psu_recon (
   input  logic                clock,
   input  logic                advance,
   input  psu_pkg::s1_ctl_type ctl,
   input  logic [7:0]          x,
   input  logic [7:0]          above,
   output logic [7:0]          value
);

   logic [7:0] left_ff  [psu_pkg::BPP];
   logic [7:0] upleft_ff[psu_pkg::BPP];
   logic [7:0] a, b, c, pred;
   logic [8:0] avg_sum;
   logic signed [9:0] d_bc, d_ac, d_p;
   logic [9:0] pa, pb, pc;

   assign a = ctl.first_pix ? 8'd0 : left_ff[ctl.lane];
   assign c = ctl.first_pix ? 8'd0 : upleft_ff[ctl.lane];
   assign b = ctl.top_row ? 8'd0 : above;

   assign avg_sum = {1'b0, a} + {1'b0, b};
   assign d_bc    = $signed({2'b00, b}) - $signed({2'b00, c});
   assign d_ac    = $signed({2'b00, a}) - $signed({2'b00, c});
   assign d_p     = d_bc + d_ac;
   assign pa      = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
   assign pb      = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
   assign pc      = d_p[9]  ? 10'(-d_p)  : 10'(d_p);

   always_comb begin
      case (ctl.filter)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         psu_pkg::FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:             pred = 8'd0;
      endcase
   end

   assign value = x + pred;

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff[ctl.lane]   <= value;
         upleft_ff[ctl.lane] <= b;
      end
   end

endmodule

// ===== rtl/core/png_scanline_unfilter_rgba8.sv =====
// png filter reconstruction for 8-bit rgba frames, one byte per cycle while the response side does not stall
// a sample request is registered in the s1 stage and then in the output register before its result is presented
// throughput: one request per cycle unless the output is stalled; a row's filter-type byte gives no result
// the previous row comes from one line store ram with a registered read
// reset clears control state and sets both frame size registers to 1
// the line store is not cleared; the first row reads it but uses zero in place of its data
module png_scanline_unfilter_rgba8 #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // in_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // out_byte
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser,   // bit 1 bad_filter, bit 0 frame_end
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [psu_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int LINE_BYTES = MAX_WIDTH * psu_pkg::BPP;
   localparam int COL_W      = $clog2(LINE_BYTES);
   localparam logic [16:0] MAXW = 17'(MAX_WIDTH);

   logic [12:0] frame_width;
   logic [15:0] frame_height;

   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      row_ff, row_in;
   logic             await_ff, await_in;
   logic             err_ff, err_in;
   psu_pkg::filter_type_type filt_ff, filt_in;

   logic                s1_v_ff, s1_v_in;
   logic [7:0]          s1_x_ff;
   logic [COL_W-1:0]    s1_col_ff;
   psu_pkg::s1_ctl_type s1_ctl_ff, s1_ctl_in;

   logic       o_v_ff, o_v_in;
   logic [7:0] o_byte_ff;
   logic       o_last_ff, o_fend_ff, o_bad_ff;

   logic             acc, sample_acc, filt_acc, out_free, s1_adv;
   logic [16:0]      wid_ext, wid_eff;
   logic [COL_W:0]   row_bytes, col_next;
   logic [15:0]      hgt_eff;
   logic [16:0]      row_next;
   logic             last_col, last_row;
   logic [7:0]       above, value;

   psu_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   assign out_free   = !o_v_ff || rsp_tready;
   assign s1_adv     = s1_v_ff && out_free;
   assign req_tready = !s1_v_ff || out_free;
   assign acc        = req_tvalid && req_tready;
   assign sample_acc = acc && !await_ff;
   assign filt_acc   = acc && await_ff;

   // effective frame size
   assign wid_ext   = {4'd0, frame_width};
   assign wid_eff   = (wid_ext == 17'd0) ? 17'd1 : ((wid_ext > MAXW) ? MAXW : wid_ext);
   assign row_bytes = (COL_W+1)'({wid_eff, 2'b00});
   assign hgt_eff   = (frame_height == 16'd0) ? 16'd1 : frame_height;
   assign col_next  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign row_next  = {1'b0, row_ff} + 17'd1;
   assign last_col  = col_next >= row_bytes;
   assign last_row  = row_next >= {1'b0, hgt_eff};

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      await_in  = await_ff;
      err_in    = err_ff;
      filt_in   = filt_ff;
      if (filt_acc) begin
         col_in   = '0;
         await_in = 1'b0;
         if (req_tdata > 8'(psu_pkg::FILT_PAETH)) begin
            filt_in = psu_pkg::FILT_NONE;
            err_in  = 1'b1;
         end else begin
            filt_in = psu_pkg::filter_type_type'(req_tdata[2:0]);
            err_in  = (row_ff == 16'd0) ? 1'b0 : err_ff;
         end
      end else if (sample_acc) begin
         if (last_col) begin
            col_in   = '0;
            await_in = 1'b1;
            row_in   = last_row ? 16'd0 : row_next[15:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_comb begin
      s1_ctl_in.filter     = filt_ff;
      s1_ctl_in.lane       = col_ff[psu_pkg::BPP_LOG2-1:0];
      s1_ctl_in.first_pix  = (col_ff >> psu_pkg::BPP_LOG2) == '0;
      s1_ctl_in.top_row    = row_ff == 16'd0;
      s1_ctl_in.row_end    = last_col;
      s1_ctl_in.frame_end  = last_col && last_row;
      s1_ctl_in.bad_filter = err_ff;
   end

   assign s1_v_in = sample_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
   assign o_v_in  = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : o_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= 16'd0;
         await_ff <= 1'b1;
         err_ff   <= 1'b0;
         filt_ff  <= psu_pkg::FILT_NONE;
         s1_v_ff  <= 1'b0;
         o_v_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         await_ff <= await_in;
         err_ff   <= err_in;
         filt_ff  <= filt_in;
         s1_v_ff  <= s1_v_in;
         o_v_ff   <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         s1_x_ff   <= req_tdata;
         s1_col_ff <= col_ff;
         s1_ctl_ff <= s1_ctl_in;
      end
      if (s1_adv) begin
         o_byte_ff <= value;
         o_last_ff <= s1_ctl_ff.row_end;
         o_fend_ff <= s1_ctl_ff.frame_end;
         o_bad_ff  <= s1_ctl_ff.bad_filter;
      end
   end

   psu_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (value),
      .rd_en   (sample_acc),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   psu_recon u_recon (
      .clock   (clock),
      .advance (s1_adv),
      .ctl     (s1_ctl_ff),
      .x       (s1_x_ff),
      .above   (above),
      .value   (value)
   );

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_byte_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tuser  = {o_bad_ff, o_fend_ff};

   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without row end");

   a_filter_clears_await: assert property (@(posedge clock) disable iff (reset)
      filt_acc |=> !await_ff && !s1_v_in || !await_ff)
      else $error("filter byte did not open a row");

   a_row_end_awaits: assert property (@(posedge clock) disable iff (reset)
      sample_acc && last_col |=> await_ff && col_ff == '0)
      else $error("row end did not wait for a filter byte");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && o_v_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while both stages are held");

   a_no_result_from_filter: assert property (@(posedge clock) disable iff (reset)
      filt_acc && !s1_v_ff |=> !s1_v_ff)
      else $error("filter byte entered the datapath");

endmodule
